// ===== rtl/core/pisc_pkg.sv =====
// Shared types, codes and limits for the PI speed controller with brake.
package pisc_pkg;

   localparam int SPEED_W  = 16;
   localparam int STAMP_W  = 32;
   localparam int GAIN_W   = 16;
   localparam int THR_W    = 15;
   localparam int ERR_W    = SPEED_W + 1;
   localparam int INTEG_W  = 48;
   localparam int MOTOR_W  = 10;
   localparam int BRAKE_W  = 7;
   localparam int MUL_A_W  = 18;
   localparam int MUL_B_W  = STAMP_W + 1;
   localparam int MUL_P_W  = MUL_A_W + MUL_B_W;
   localparam int ACC_W    = 64;
   localparam int INTEG_LO = 24;

   localparam logic [1:0] OP_MEASURE = 2'd0;
   localparam logic [1:0] OP_TARGET  = 2'd1;
   localparam logic [1:0] OP_ON      = 2'd2;
   localparam logic [1:0] OP_OFF     = 2'd3;

   localparam logic [1:0] REG_MOTOR_PROP = 2'd0;
   localparam logic [1:0] REG_MOTOR_INTEG = 2'd1;
   localparam logic [1:0] REG_BRAKE_PROP = 2'd2;
   localparam logic [1:0] REG_BRAKE_THR  = 2'd3;

   localparam logic [MOTOR_W-1:0] MOTOR_LIMIT = 10'd1000;
   localparam logic [BRAKE_W-1:0] BRAKE_HIGH  = 7'd100;
   localparam logic [BRAKE_W-1:0] BRAKE_LOW   = 7'd1;

   typedef struct packed {
      logic [GAIN_W-1:0] motor_prop_gain;
      logic [GAIN_W-1:0] motor_integ_gain;
      logic [GAIN_W-1:0] brake_prop_gain;
      logic [THR_W-1:0]  brake_threshold;
   } cfg_type;

endpackage

// ===== rtl/core/pi_speed_control_with_brake_core.sv =====
// PI speed controller with overspeed brake: sequencer and datapath top level.
//
// Request channel (req_): operation, speed_value, time_stamp. Operation 0 is a
// speed measurement, 1 sets the target, 2 switches the loop on, 3 switches it
// off. Only a measurement taken while the loop is on yields a response.
// Response channel (rsp_): motor_command, brake_command and the stamp echo.
// Configuration (csr_): index 0..3 selects Kp, Ki, Kb and the brake threshold;
// csr_ready is always high; write only while the block is idle.
// Target, on and off requests complete in the accept cycle; the block is ready
// again on the next cycle. A measurement steps through ERRDT, INTEG, PROP, ILO,
// IHI and DONE on one shared 18x33 multiplier (err*dt, Kp*err, Ki*integral in
// two halves, Kb*err); the response is registered in DONE, and no new request
// is taken until the sequencer is back in idle.
// A finished response sits in an output register; if the receiver stalls and
// a new result is ready, the sequencer holds in its final step until the
// pending response is taken.
// Synchronous reset clears all gains, the target, the integral, the latched
// stamp, switches the loop off and drops any pending response.
module pi_speed_control_with_brake_core (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [1:0]                    req_operation,
   input  logic [pisc_pkg::SPEED_W-1:0]  req_speed_value,
   input  logic [pisc_pkg::STAMP_W-1:0]  req_time_stamp,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [pisc_pkg::MOTOR_W-1:0]  rsp_motor_command,
   output logic [pisc_pkg::BRAKE_W-1:0]  rsp_brake_command,
   output logic [pisc_pkg::STAMP_W-1:0]  rsp_stamp_echo,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [1:0]                    csr_index,
   input  logic [pisc_pkg::GAIN_W-1:0]   csr_wdata
);
   import pisc_pkg::*;

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_ERRDT = 3'd1;
   localparam logic [2:0] ST_INTEG = 3'd2;
   localparam logic [2:0] ST_PROP  = 3'd3;
   localparam logic [2:0] ST_ILO   = 3'd4;
   localparam logic [2:0] ST_IHI   = 3'd5;
   localparam logic [2:0] ST_DONE  = 3'd6;

   cfg_type cfg;

   logic [2:0]         state_ff, state_in;
   logic               loop_ff, loop_in;
   logic [SPEED_W-1:0] target_ff, target_in;
   logic [STAMP_W-1:0] last_ff, last_in;
   logic [INTEG_W-1:0] integ_ff, integ_in;
   logic [ERR_W-1:0]   err_ff, err_in;
   logic [STAMP_W-1:0] dt_ff, dt_in;
   logic [STAMP_W-1:0] stamp_ff, stamp_in;
   logic [ACC_W-1:0]   acc_ff, acc_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [MOTOR_W-1:0] motor_ff, motor_in;
   logic [BRAKE_W-1:0] brake_cmd_ff, brake_cmd_in;
   logic [STAMP_W-1:0] echo_ff, echo_in;

   logic               accept;
   logic               mul_en;
   logic [MUL_A_W-1:0] mul_a;
   logic [MUL_B_W-1:0] mul_b;
   logic [MUL_P_W-1:0] prod;
   logic [ACC_W-1:0]   prod_ext;
   logic [INTEG_W+1:0] isum;
   logic [INTEG_W-1:0] isat;
   logic [ERR_W-1:0]   neg_thr;
   logic               braking;
   logic [MOTOR_W-1:0] motor_val;
   logic [BRAKE_W-1:0] brake_val;
   logic [ERR_W-1:0]   brake_int;
   logic               out_free;

   pisc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   pisc_mult u_mult (
      .clock  (clock),
      .enable (mul_en),
      .op_a   (mul_a),
      .op_b   (mul_b),
      .prod   (prod)
   );

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_motor_command = motor_ff;
   assign rsp_brake_command = brake_cmd_ff;
   assign rsp_stamp_echo    = echo_ff;

   assign prod_ext = {{(ACC_W-MUL_P_W){prod[MUL_P_W-1]}}, prod};

   // integral update with saturation to 48 bits
   assign isum = {{2{integ_ff[INTEG_W-1]}}, integ_ff} + prod[INTEG_W+1:0];
   always_comb begin
      if (isum[INTEG_W+1:INTEG_W-1] == 3'b000 || isum[INTEG_W+1:INTEG_W-1] == 3'b111) begin
         isat = isum[INTEG_W-1:0];
      end else if (isum[INTEG_W+1]) begin
         isat = {1'b1, {(INTEG_W-1){1'b0}}};
      end else begin
         isat = {1'b0, {(INTEG_W-1){1'b1}}};
      end
   end

   // operand select for the shared multiplier
   always_comb begin
      mul_en = 1'b1;
      mul_a  = '0;
      mul_b  = '0;
      case (state_ff)
         ST_ERRDT: begin
            mul_a = {err_ff[ERR_W-1], err_ff};
            mul_b = {1'b0, dt_ff};
         end
         ST_INTEG: begin
            mul_a = {{(MUL_A_W-GAIN_W){cfg.motor_prop_gain[GAIN_W-1]}}, cfg.motor_prop_gain};
            mul_b = {{(MUL_B_W-ERR_W){err_ff[ERR_W-1]}}, err_ff};
         end
         ST_PROP: begin
            mul_a = {{(MUL_A_W-GAIN_W){cfg.motor_integ_gain[GAIN_W-1]}},
                     cfg.motor_integ_gain};
            mul_b = {{(MUL_B_W-INTEG_LO){1'b0}}, integ_ff[INTEG_LO-1:0]};
         end
         ST_ILO: begin
            mul_a = {{(MUL_A_W-GAIN_W){cfg.motor_integ_gain[GAIN_W-1]}},
                     cfg.motor_integ_gain};
            mul_b = {{(MUL_B_W-(INTEG_W-INTEG_LO)){integ_ff[INTEG_W-1]}},
                     integ_ff[INTEG_W-1:INTEG_LO]};
         end
         ST_IHI: begin
            mul_a = {{(MUL_A_W-GAIN_W){cfg.brake_prop_gain[GAIN_W-1]}}, cfg.brake_prop_gain};
            mul_b = {{(MUL_B_W-ERR_W){err_ff[ERR_W-1]}}, err_ff};
         end
         default: mul_en = 1'b0;
      endcase
   end

   // output shaping: motor from acc, brake from Kb*err in the product register
   assign neg_thr   = '0 - {{(ERR_W-THR_W){1'b0}}, cfg.brake_threshold};
   assign braking   = $signed(err_ff) < $signed(neg_thr);
   assign brake_int = prod[ERR_W+15:16];

   always_comb begin
      if (acc_ff[ACC_W-1]) begin
         motor_val = '0;
      end else if (acc_ff[ACC_W-2:32] > {{(ACC_W-33-MOTOR_W){1'b0}}, MOTOR_LIMIT}) begin
         motor_val = MOTOR_LIMIT;
      end else begin
         motor_val = acc_ff[32+MOTOR_W-1:32];
      end
   end

   always_comb begin
      if (prod[MUL_P_W-1] || prod == '0) begin
         brake_val = BRAKE_LOW;
      end else if (brake_int > {{(ERR_W-BRAKE_W){1'b0}}, BRAKE_HIGH}) begin
         brake_val = BRAKE_HIGH;
      end else if (brake_int < {{(ERR_W-BRAKE_W){1'b0}}, BRAKE_LOW}) begin
         brake_val = BRAKE_LOW;
      end else begin
         brake_val = brake_int[BRAKE_W-1:0];
      end
   end

   always_comb begin
      state_in     = state_ff;
      loop_in      = loop_ff;
      target_in    = target_ff;
      last_in      = last_ff;
      integ_in     = integ_ff;
      err_in       = err_ff;
      dt_in        = dt_ff;
      stamp_in     = stamp_ff;
      acc_in       = acc_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      motor_in     = motor_ff;
      brake_cmd_in = brake_cmd_ff;
      echo_in      = echo_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_operation)
                  OP_TARGET: target_in = req_speed_value;
                  OP_ON, OP_OFF: begin
                     integ_in = '0;
                     last_in  = req_time_stamp;
                     loop_in  = (req_operation == OP_ON);
                  end
                  default: begin
                     if (loop_ff) begin
                        err_in   = {target_ff[SPEED_W-1], target_ff}
                                 - {req_speed_value[SPEED_W-1], req_speed_value};
                        dt_in    = req_time_stamp - last_ff;
                        last_in  = req_time_stamp;
                        stamp_in = req_time_stamp;
                        state_in = ST_ERRDT;
                     end
                  end
               endcase
            end
         end
         ST_ERRDT: state_in = ST_INTEG;
         ST_INTEG: begin
            integ_in = isat;
            state_in = ST_PROP;
         end
         ST_PROP: begin
            acc_in   = prod_ext << 16;
            state_in = ST_ILO;
         end
         ST_ILO: begin
            acc_in   = acc_ff + prod_ext;
            state_in = ST_IHI;
         end
         ST_IHI: begin
            acc_in   = acc_ff + (prod_ext << INTEG_LO);
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               motor_in     = braking ? '0 : motor_val;
               brake_cmd_in = braking ? brake_val : BRAKE_LOW;
               echo_in      = stamp_ff;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         loop_ff      <= 1'b0;
         target_ff    <= '0;
         last_ff      <= '0;
         integ_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         loop_ff      <= loop_in;
         target_ff    <= target_in;
         last_ff      <= last_in;
         integ_ff     <= integ_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      err_ff       <= err_in;
      dt_ff        <= dt_in;
      stamp_ff     <= stamp_in;
      acc_ff       <= acc_in;
      motor_ff     <= motor_in;
      brake_cmd_ff <= brake_cmd_in;
      echo_ff      <= echo_in;
   end

   a_motor_limit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_motor_command <= MOTOR_LIMIT)
      else $error("motor command above limit");

   a_brake_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_brake_command >= BRAKE_LOW && rsp_brake_command <= BRAKE_HIGH))
      else $error("brake command out of range");

   a_drive_or_brake: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_motor_command != '0) |-> rsp_brake_command == BRAKE_LOW)
      else $error("drive and brake both active");

   a_busy_after_measure: assert property (@(posedge clock) disable iff (reset)
      (accept && req_operation == OP_MEASURE && loop_ff) |=> !req_ready)
      else $error("measurement did not start the sequencer");

   a_switch_clears: assert property (@(posedge clock) disable iff (reset)
      (accept && (req_operation == OP_ON || req_operation == OP_OFF)) |=> integ_ff == '0)
      else $error("switch request did not clear the integral");

endmodule

// ===== rtl/core/pisc_csr.sv =====
// Configuration register file: gains and brake threshold.
module pisc_csr (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic [1:0]              csr_index,
   input  logic [pisc_pkg::GAIN_W-1:0] csr_wdata,
   output pisc_pkg::cfg_type       cfg
);
   import pisc_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            REG_MOTOR_PROP:  cfg_in.motor_prop_gain  = csr_wdata;
            REG_MOTOR_INTEG: cfg_in.motor_integ_gain = csr_wdata;
            REG_BRAKE_PROP:  cfg_in.brake_prop_gain  = csr_wdata;
            REG_BRAKE_THR:   cfg_in.brake_threshold  = csr_wdata[THR_W-1:0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ===== rtl/core/pisc_mult.sv =====
// Shared signed multiplier with registered product.
module pisc_mult (
   input  logic                         clock,
   input  logic                         enable,
   input  logic [pisc_pkg::MUL_A_W-1:0] op_a,
   input  logic [pisc_pkg::MUL_B_W-1:0] op_b,
   output logic [pisc_pkg::MUL_P_W-1:0] prod
);
   import pisc_pkg::*;

   logic signed [MUL_P_W-1:0] prod_in;
   logic [MUL_P_W-1:0]        prod_ff;

   assign prod_in = $signed(op_a) * $signed(op_b);
   assign prod = prod_ff;

   always_ff @(posedge clock) begin
      if (enable) begin
         prod_ff <= prod_in;
      end
   end

endmodule
